// File: design/prt_pkg.sv
// Package for the polled reload timer.
// Holds the channel payload types, operation codes and internal command and state types.
// No dependencies.
package prt_pkg;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_POLL    = 3'd4;

  localparam int unsigned TICK_W   = 64;
  localparam int unsigned PERIOD_W = 32;

  typedef struct packed {
    logic [2:0]          operation;
    logic [PERIOD_W-1:0] interval;
    logic                reload_mode;
  } in_item_t;

  typedef struct packed {
    logic fired;
    logic enabled_now;
    logic running;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_START,
    CMD_RESTART,
    CMD_STOP,
    CMD_POLL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [PERIOD_W-1:0] interval;
    logic                reload_mode;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } back_state_t;

endpackage

// File: design/polled_reload_timer.sv
// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_stall
// out_      output     out_item_t  out_valid / out_stall
//
// Top level of the polled reload timer: front decoder, command queue and back end.
// Depends on prt_pkg, prt_front, prt_queue and prt_back.
// Every item passes the back end's idle and finish states; a poll that fires in reload
// mode with a nonzero period also waits on the bit-serial 64-bit remainder unit.
// The queue keeps taking items while the back end works, up to QUEUE_DEPTH.
// A result waits in the output register under out_stall; the next result holds in ST_FIN.
// Reset is synchronous and clears the timer state, queue and output valid.
module polled_reload_timer import prt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_in_cmd, q_head_cmd;

  prt_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd)
  );

  prt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_head_cmd)
  );

  prt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: design/prt_front.sv
// Front end of the polled reload timer: takes input transfers and decodes them into commands.
// Depends on prt_pkg.
module prt_front import prt_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.interval    = in_item.interval;
    q_cmd.reload_mode = in_item.reload_mode;
    unique case (in_item.operation)
      OP_TICK:    q_cmd.kind = CMD_TICK;
      OP_START:   q_cmd.kind = CMD_START;
      OP_RESTART: q_cmd.kind = CMD_RESTART;
      OP_STOP:    q_cmd.kind = CMD_STOP;
      OP_POLL:    q_cmd.kind = CMD_POLL;
      default:    q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// File: design/prt_queue.sv
// Command queue between the front and back ends of the polled reload timer.
// Depends on prt_pkg.
module prt_queue import prt_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign head_cmd = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/prt_mod.sv
// Bit-serial remainder unit of the polled reload timer: 64-bit dividend modulo 32-bit divisor.
// One dividend bit per cycle, restoring. Depends on prt_pkg.
module prt_mod import prt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TICK_W-1:0]   dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [PERIOD_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(TICK_W);

  logic [TICK_W-1:0]   quo_r;
  logic [PERIOD_W-1:0] div_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [PERIOD_W:0]   rem_shift;
  logic [PERIOD_W:0]   rem_nxt;

  assign rem_shift = {rem_r, quo_r[TICK_W-1]};
  assign rem_nxt   = (rem_shift >= {1'b0, div_r}) ? rem_shift - {1'b0, div_r} : rem_shift;
  assign done      = done_r;
  assign rem       = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(TICK_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[TICK_W-2:0], 1'b0};
      rem_r <= rem_nxt[PERIOD_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule

// File: design/prt_back.sv
// Back end of the polled reload timer: timer state, command execution and result register.
// Depends on prt_pkg and prt_mod.
module prt_back import prt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  back_state_t         state_r, state_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [TICK_W-1:0]   expiry_r, expiry_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                enabled_r, enabled_nxt;
  logic                expired_r, expired_nxt;
  logic                reload_r, reload_nxt;
  logic                fired_r, fired_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;
  logic                out_load;
  logic [TICK_W:0]     over_diff;
  logic                mod_start, mod_done;
  logic [PERIOD_W-1:0] mod_rem;

  assign over_diff = {1'b0, tick_r} - {1'b0, expiry_r};

  prt_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (over_diff[TICK_W-1:0]),
    .divisor  (period_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    expiry_nxt  = expiry_r;
    period_nxt  = period_r;
    enabled_nxt = enabled_r;
    expired_nxt = expired_r;
    reload_nxt  = reload_r;
    fired_nxt   = fired_r;
    q_pop       = 1'b0;
    mod_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          fired_nxt = 1'b0;
          state_nxt = ST_FIN;
          case (q_cmd.kind)
            CMD_TICK: begin
              tick_nxt = tick_r + TICK_W'(1);
            end
            CMD_START: begin
              expiry_nxt  = tick_r + TICK_W'(q_cmd.interval);
              period_nxt  = q_cmd.interval;
              expired_nxt = 1'b0;
              reload_nxt  = q_cmd.reload_mode;
              enabled_nxt = 1'b1;
            end
            CMD_RESTART: begin
              if (period_r != '0) begin
                expiry_nxt  = tick_r + TICK_W'(period_r);
                expired_nxt = 1'b0;
                enabled_nxt = 1'b1;
              end
            end
            CMD_STOP: begin
              enabled_nxt = 1'b0;
            end
            CMD_POLL: begin
              if (enabled_r) begin
                if (!over_diff[TICK_W]) begin
                  fired_nxt = 1'b1;
                  if (!reload_r) begin
                    expired_nxt = 1'b1;
                  end else if (period_r == '0) begin
                    expiry_nxt = tick_r;
                  end else begin
                    mod_start = 1'b1;
                    state_nxt = ST_DIV;
                  end
                end else begin
                  fired_nxt = expired_r;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          expiry_nxt = tick_r + TICK_W'(period_r - mod_rem);
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt            = out_valid_r && out_stall;
    out_item_nxt             = out_item_r;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.fired       = fired_r;
      out_item_nxt.enabled_now = enabled_r;
      out_item_nxt.running     = enabled_r && (tick_r < expiry_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      expiry_r    <= '0;
      period_r    <= '0;
      enabled_r   <= 1'b0;
      expired_r   <= 1'b0;
      reload_r    <= 1'b0;
      fired_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      expiry_r    <= expiry_nxt;
      period_r    <= period_nxt;
      enabled_r   <= enabled_nxt;
      expired_r   <= expired_nxt;
      reload_r    <= reload_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/prt_checker.sv
// Port-level checker for the polled reload timer, bound to the top level.
// Depends on prt_pkg.
module prt_checker import prt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_running_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_item.running || out_item.enabled_now)
    else $error("running reported while disabled");

  a_fired_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.fired |-> out_item.enabled_now)
    else $error("fired reported while disabled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind polled_reload_timer prt_checker u_prt_checker (.*);
